@@ sv/ctt_pkg.sv @@
package ctt_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EOC    = 8'hFF;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOC  = 2'd2;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_PLAIN   = 3'd1,
    MODE_QUOTED  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_DONE    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic [1:0] result_kind;
    logic       last_of_run;
  } out_item_t;

  // One queue entry holds every result of one input transaction.
  typedef struct packed {
    out_item_t res0;
    out_item_t res1;
    logic      two;
  } entry_t;

  function automatic logic is_sep(input logic [7:0] c);
    return c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_TAB ||
           c == CH_SPACE || c == CH_COMMA;
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return c == CH_DQUOTE || c == CH_SQUOTE;
  endfunction

endpackage

@@ sv/ctt_front.sv @@
module ctt_front
  import ctt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_ready,
  output logic     q_push,
  output entry_t   q_entry
);

  mode_t      mode_r, mode_nxt;
  logic       comments_en_r;
  logic [7:0] c;
  logic       eoi;
  logic       accept;
  logic [1:0] n;
  out_item_t  r0, r1;

  assign c        = in_data.text_byte;
  assign eoi      = in_data.end_of_input;
  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_BETWEEN;
      comments_en_r <= 1'b1;
    end else begin
      if (accept) mode_r <= mode_nxt;
      if (cfg_we) comments_en_r <= cfg_wdata;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    if (eoi) begin
      mode_nxt = MODE_BETWEEN;
    end else begin
      case (mode_r)
        MODE_PLAIN: begin
          if (is_sep(c)) mode_nxt = MODE_BETWEEN;
        end
        MODE_QUOTED: begin
          if (is_quote(c)) mode_nxt = MODE_BETWEEN;
        end
        MODE_COMMENT: begin
          if (c == CH_LF || c == CH_CR) mode_nxt = MODE_BETWEEN;
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) mode_nxt = MODE_COMMENT;
          else if (is_sep(c)) mode_nxt = MODE_BETWEEN;
          else mode_nxt = MODE_PLAIN;
        end
        MODE_DONE: begin
          mode_nxt = MODE_DONE;
        end
        default: begin
          if (is_sep(c)) mode_nxt = MODE_BETWEEN;
          else if (c == CH_EOC) mode_nxt = MODE_DONE;
          else if (comments_en_r && c == CH_HASH) mode_nxt = MODE_COMMENT;
          else if (comments_en_r && c == CH_SLASH) mode_nxt = MODE_SLASH;
          else if (is_quote(c)) mode_nxt = MODE_QUOTED;
          else mode_nxt = MODE_PLAIN;
        end
      endcase
    end
  end

  always_comb begin
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    if (eoi) begin
      case (mode_r)
        MODE_PLAIN, MODE_QUOTED: begin
          n              = 2'd1;
          r0.result_kind = KIND_END;
        end
        MODE_SLASH: begin
          n              = 2'd2;
          r0.token_char  = CH_SLASH;
          r0.result_kind = KIND_CHAR;
          r1.result_kind = KIND_END;
        end
        default: n = 2'd0;
      endcase
    end else begin
      case (mode_r)
        MODE_PLAIN: begin
          n = 2'd1;
          if (is_sep(c)) r0.result_kind = KIND_END;
          else r0.token_char = c;
        end
        MODE_QUOTED: begin
          n = 2'd1;
          if (is_quote(c)) r0.result_kind = KIND_END;
          else r0.token_char = (c == CH_TAB) ? CH_SPACE : c;
        end
        MODE_COMMENT: n = 2'd0;
        MODE_SLASH: begin
          // Release the held slash, then treat this byte as inside a plain token (a separator ends it).
          if (c != CH_SLASH) begin
            n             = 2'd2;
            r0.token_char = CH_SLASH;
            if (is_sep(c)) r1.result_kind = KIND_END;
            else r1.token_char = c;
          end
        end
        MODE_DONE: n = 2'd0;
        default: begin
          if (is_sep(c)) begin
            n = 2'd0;
          end else if (c == CH_EOC) begin
            n              = 2'd1;
            r0.result_kind = KIND_EOC;
          end else if (comments_en_r && (c == CH_HASH || c == CH_SLASH)) begin
            n = 2'd0;
          end else if (is_quote(c)) begin
            n = 2'd0;
          end else begin
            n             = 2'd1;
            r0.token_char = c;
          end
        end
      endcase
    end
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = (n == 2'd2);
  end

  assign q_push        = accept && (n != 2'd0);
  assign q_entry.res0  = r0;
  assign q_entry.res1  = r1;
  assign q_entry.two   = (n == 2'd2);

endmodule

@@ sv/ctt_queue.sv @@
module ctt_queue
  import ctt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   ready,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  entry_t        slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign ready      = (count_r != FULL);
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

@@ sv/ctt_back.sv @@
module ctt_back
  import ctt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  entry_t    head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_r;
  logic      sel_r, sel_nxt;
  logic      load, last_sel;
  out_item_t cur;

  assign load     = head_valid && (!out_valid_r || out_ready);
  assign last_sel = !head.two || sel_r;
  assign cur      = sel_r ? head.res1 : head.res0;
  assign pop      = load && last_sel;
  assign sel_nxt  = load ? !last_sel : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= cur;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Second half of a two-result entry must still sit at the queue head.
  a_sel_head: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (head_valid && head.two))
    else $error("second result selected without a two-result head entry");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cur.last_of_run)
    else $error("entry popped before its last result was loaded");

  a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.result_kind != KIND_CHAR) |-> (out_r.token_char == 8'h00))
    else $error("mark result carries a nonzero character");

endmodule

@@ sv/command_text_tokenizer.sv @@
// Channel   Direction  Payload     Handshake
// in_       input      in_item_t   in_valid / in_ready
// out_      output     out_item_t  out_valid / out_ready
// cfg_      input      1 bit       cfg_we, no wait
//
// One input transaction per cycle while in_ready is high; its results leave the
// output register one per cycle while out_ready is high, one result after another.
// The classifier takes a byte whenever the result queue (QUEUE_DEPTH entries)
// has room; a stalled output fills the queue and then drops in_ready.
// An input's first result passes through the queue, then the output register.
// Reset (rst_n, synchronous) empties the queue, sets scan mode to between
// tokens and enables comments.
module command_text_tokenizer
  import ctt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic   q_ready, q_push, q_pop, q_head_valid;
  entry_t q_entry, q_head;

  ctt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  ctt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ctt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
